/* rtl/hkad_pkg.sv */
// Shared types and constants for the H.264 keyframe access unit detector.
`timescale 1ns / 1ps

package hkad_pkg;

   localparam int OFFSET_BITS = 48;
   localparam int TYPE_BITS   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] WINDOW_RESET = 32'hffffffff;
   localparam logic [31:0] START_MASK   = 32'hffffff00;
   localparam logic [31:0] START_MATCH  = 32'h00000100;

   localparam logic [TYPE_BITS-1:0] TYPE_NONE      = 5'd0;
   localparam logic [TYPE_BITS-1:0] TYPE_SLICE     = 5'd1;
   localparam logic [TYPE_BITS-1:0] TYPE_IDR       = 5'd5;
   localparam logic [TYPE_BITS-1:0] TYPE_SEI       = 5'd6;
   localparam logic [TYPE_BITS-1:0] TYPE_SPS       = 5'd7;
   localparam logic [TYPE_BITS-1:0] TYPE_PPS       = 5'd8;
   localparam logic [TYPE_BITS-1:0] TYPE_AUD       = 5'd9;
   localparam logic [TYPE_BITS-1:0] TYPE_EOSEQ     = 5'd10;
   localparam logic [TYPE_BITS-1:0] TYPE_SPS_EXT   = 5'd13;
   localparam logic [TYPE_BITS-1:0] TYPE_AUX_SLICE = 5'd19;

   typedef struct packed {
      logic                   start_found;
      logic [TYPE_BITS-1:0]   unit_type;
      logic [OFFSET_BITS-1:0] byte_offset;
   } hkad_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } hkad_qstat_type;

endpackage

/* rtl/hkad_front.sv */
// Front end: start code window and NAL header classification per byte.
`timescale 1ns / 1ps

module hkad_front import hkad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic [OFFSET_BITS-1:0] req_byte_offset,
   input  hkad_qstat_type         qstat,
   output logic                   push,
   output hkad_item_type          push_item
);

   logic [31:0] window_ff;
   logic [31:0] window_in;
   logic        found;

   assign req_ready = !qstat.full;
   assign push      = req_valid && !qstat.full;
   assign window_in = {window_ff[23:0], req_data_byte};
   assign found     = (window_in & START_MASK) == START_MATCH;

   always_comb begin
      push_item.start_found = found;
      push_item.unit_type   = found ? req_data_byte[TYPE_BITS-1:0] : TYPE_NONE;
      push_item.byte_offset = req_byte_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (push) begin
         window_ff <= window_in;
      end
   end

endmodule

/* rtl/hkad_queue.sv */
// Short queue of classified beats between the front and back ends.
`timescale 1ns / 1ps

module hkad_queue import hkad_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  hkad_item_type  push_item,
   input  logic           pop,
   output hkad_item_type  head_item,
   output hkad_qstat_type qstat
);

   hkad_item_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;

   assign head_item   = entries_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign qstat.empty = count_ff == '0;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/hkad_back.sv */
// Back end: access unit and keyframe tracking with the result register.
`timescale 1ns / 1ps

module hkad_back import hkad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  hkad_item_type          head_item,
   input  hkad_qstat_type         qstat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_start_found,
   output logic [TYPE_BITS-1:0]   rsp_unit_type,
   output logic                   rsp_is_keyframe,
   output logic                   rsp_on_frame,
   output logic                   rsp_changed,
   output logic [OFFSET_BITS-1:0] rsp_unit_start_offset
);

   logic                   valid_ff;
   logic [TYPE_BITS-1:0]   prev_type_ff, prev_type_in;
   logic                   unit_opened_ff, unit_opened_in;
   logic                   seen_vcl_ff, seen_vcl_in;
   logic                   seen_ps_ff, seen_ps_in;
   logic                   evaluated_ff, evaluated_in;
   logic                   key_ff, key_in;
   logic [OFFSET_BITS-1:0] saved_offset_ff, saved_offset_in;
   logic                   found_ff;
   logic [TYPE_BITS-1:0]   type_ff;
   logic                   changed_ff, changed_in;
   logic                   opens_unit;
   logic                   is_vcl;
   logic [TYPE_BITS-1:0]   t;

   assign pop = !qstat.empty && (!valid_ff || rsp_ready);
   assign t   = head_item.unit_type;

   assign is_vcl     = (t >= TYPE_SLICE) && (t <= TYPE_IDR);
   assign opens_unit = (t == TYPE_AUD) || (prev_type_ff == TYPE_EOSEQ) ||
                       (t == TYPE_SEI) || (t == TYPE_SPS) || (t == TYPE_PPS) ||
                       ((t > TYPE_SPS_EXT) && (t < TYPE_AUX_SLICE));

   always_comb begin
      prev_type_in    = prev_type_ff;
      unit_opened_in  = unit_opened_ff;
      seen_vcl_in     = seen_vcl_ff;
      seen_ps_in      = seen_ps_ff;
      evaluated_in    = evaluated_ff;
      key_in          = key_ff;
      saved_offset_in = saved_offset_ff;
      changed_in      = 1'b0;
      if (head_item.start_found) begin
         key_in = 1'b0;
         if ((seen_vcl_ff || !evaluated_ff) && !unit_opened_ff) begin
            evaluated_in = 1'b1;
            if (opens_unit) begin
               seen_vcl_in     = 1'b0;
               unit_opened_in  = 1'b1;
               saved_offset_in = head_item.byte_offset;
            end
         end
         if (!seen_vcl_in && !seen_ps_ff && (t == TYPE_SPS)) begin
            seen_ps_in = 1'b1;
            changed_in = 1'b1;
         end
         if (!seen_vcl_in && is_vcl) begin
            seen_vcl_in    = 1'b1;
            unit_opened_in = 1'b0;
            changed_in     = 1'b1;
            key_in         = seen_ps_in;
            seen_ps_in     = 1'b0;
         end
         prev_type_in = t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         prev_type_ff    <= TYPE_NONE;
         unit_opened_ff  <= 1'b0;
         seen_vcl_ff     <= 1'b0;
         seen_ps_ff      <= 1'b0;
         evaluated_ff    <= 1'b0;
         key_ff          <= 1'b0;
         saved_offset_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff        <= 1'b1;
            prev_type_ff    <= prev_type_in;
            unit_opened_ff  <= unit_opened_in;
            seen_vcl_ff     <= seen_vcl_in;
            seen_ps_ff      <= seen_ps_in;
            evaluated_ff    <= evaluated_in;
            key_ff          <= key_in;
            saved_offset_ff <= saved_offset_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         found_ff   <= head_item.start_found;
         type_ff    <= t;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_start_found       = found_ff;
   assign rsp_unit_type         = type_ff;
   assign rsp_is_keyframe       = key_ff;
   assign rsp_on_frame          = seen_vcl_ff;
   assign rsp_changed           = changed_ff;
   assign rsp_unit_start_offset = saved_offset_ff;

endmodule

/* rtl/h264_keyframe_access_unit_detector_top.sv */
// Top level of the H.264 Annex B keyframe access unit detector.
// The block takes one stream byte per beat and returns one result beat per byte, in order.
// It sustains one byte per clock cycle while the queue is not full. Each byte is written
// to the queue, then its result is registered in the back end. The front end finds start
// codes and classifies NAL headers, a four-entry queue absorbs output stalls, and the back
// end updates the access unit and keyframe state once per byte, which sets the rate.
`timescale 1ns / 1ps

module h264_keyframe_access_unit_detector_top import hkad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic [OFFSET_BITS-1:0] req_byte_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_start_found,
   output logic [TYPE_BITS-1:0]   rsp_unit_type,
   output logic                   rsp_is_keyframe,
   output logic                   rsp_on_frame,
   output logic                   rsp_changed,
   output logic [OFFSET_BITS-1:0] rsp_unit_start_offset
);

   hkad_qstat_type qstat;
   hkad_item_type  push_item;
   hkad_item_type  head_item;
   logic           push;
   logic           pop;

   hkad_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_byte_offset(req_byte_offset),
      .qstat          (qstat),
      .push           (push),
      .push_item      (push_item)
   );

   hkad_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .head_item(head_item),
      .qstat    (qstat)
   );

   hkad_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_item            (head_item),
      .qstat                (qstat),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_start_found      (rsp_start_found),
      .rsp_unit_type        (rsp_unit_type),
      .rsp_is_keyframe      (rsp_is_keyframe),
      .rsp_on_frame         (rsp_on_frame),
      .rsp_changed          (rsp_changed),
      .rsp_unit_start_offset(rsp_unit_start_offset)
   );

endmodule

/* rtl/hkad_checker.sv */
// Port-level checks for the keyframe access unit detector and their binding.
`timescale 1ns / 1ps

module hkad_checker import hkad_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [7:0]             req_data_byte,
   input logic [OFFSET_BITS-1:0] req_byte_offset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_start_found,
   input logic [TYPE_BITS-1:0]   rsp_unit_type,
   input logic                   rsp_is_keyframe,
   input logic                   rsp_on_frame,
   input logic                   rsp_changed,
   input logic [OFFSET_BITS-1:0] rsp_unit_start_offset
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_start_offset) &&
         $stable(rsp_unit_type) && $stable(rsp_is_keyframe) && $stable(rsp_on_frame))
      else $error("Stalled result beat changed.");

   a_no_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_start_found |-> rsp_unit_type == TYPE_NONE && !rsp_changed)
      else $error("Non-header beat carries a type or a state change.");

   a_key_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_keyframe |-> rsp_on_frame)
      else $error("Keyframe flagged outside a frame.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result beat offered right after reset.");

endmodule

bind h264_keyframe_access_unit_detector_top hkad_checker u_hkad_checker (.*);

/* verif/hkad_au_checker.sv */
// Checker for the keyframe access unit detector: predicts each result beat and compares it.
`timescale 1ns / 1ps

module hkad_au_checker import hkad_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic [OFFSET_BITS-1:0] req_byte_offset,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_start_found,
   input  logic [TYPE_BITS-1:0]   rsp_unit_type,
   input  logic                   rsp_is_keyframe,
   input  logic                   rsp_on_frame,
   input  logic                   rsp_changed,
   input  logic [OFFSET_BITS-1:0] rsp_unit_start_offset,
   output int                     mismatch_count,
   output int                     verdicts_awaited
);

   typedef struct packed {
      logic                   start_found;
      logic [TYPE_BITS-1:0]   unit_type;
      logic                   is_keyframe;
      logic                   on_frame;
      logic                   changed;
      logic [OFFSET_BITS-1:0] unit_start_offset;
   } au_verdict_type;

   logic [31:0]            window;
   logic [TYPE_BITS-1:0]   last_type;
   logic                   unit_open;
   logic                   in_frame;
   logic                   sps_seen;
   logic                   first_done;
   logic                   key;
   logic [OFFSET_BITS-1:0] unit_offset;
   au_verdict_type         awaited_verdicts[$];
   int                     fault_total = 0;

   function automatic au_verdict_type classify_byte(input logic [7:0] b,
                                                    input logic [OFFSET_BITS-1:0] off);
      au_verdict_type       v;
      logic                 found;
      logic                 chg;
      logic [TYPE_BITS-1:0] t;
      window = {window[23:0], b};
      found  = (window & START_MASK) == START_MATCH;
      chg    = 1'b0;
      t      = TYPE_NONE;
      if (found) begin
         t   = b[TYPE_BITS-1:0];
         key = 1'b0;
         if ((in_frame || !first_done) && !unit_open) begin
            first_done = 1'b1;
            if (t == TYPE_AUD || last_type == TYPE_EOSEQ || t == TYPE_SEI ||
                t == TYPE_SPS || t == TYPE_PPS ||
                (t > TYPE_SPS_EXT && t < TYPE_AUX_SLICE)) begin
               in_frame    = 1'b0;
               unit_open   = 1'b1;
               unit_offset = off;
            end
         end
         if (!in_frame && !sps_seen && t == TYPE_SPS) begin
            sps_seen = 1'b1;
            chg      = 1'b1;
            key      = 1'b0;
         end
         if (!in_frame && t >= TYPE_SLICE && t <= TYPE_IDR) begin
            in_frame  = 1'b1;
            unit_open = 1'b0;
            chg       = 1'b1;
            key       = sps_seen;
            sps_seen  = 1'b0;
         end
         last_type = t;
      end
      v.start_found       = found;
      v.unit_type         = t;
      v.is_keyframe       = key;
      v.on_frame          = in_frame;
      v.changed           = chg;
      v.unit_start_offset = unit_offset;
      return v;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fault_total++;
      end
   endfunction

   always @(posedge clock) begin
      au_verdict_type exp_v;
      if (reset) begin
         window      = WINDOW_RESET;
         last_type   = TYPE_NONE;
         unit_open   = 1'b0;
         in_frame    = 1'b0;
         sps_seen    = 1'b0;
         first_done  = 1'b0;
         key         = 1'b0;
         unit_offset = '0;
         awaited_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_verdicts.size() == 0) begin
               $error("result beat with no byte awaiting its result");
               fault_total++;
            end else begin
               exp_v = awaited_verdicts.pop_front();
               check_field("start_found", exp_v.start_found, rsp_start_found);
               check_field("unit_type", exp_v.unit_type, rsp_unit_type);
               check_field("is_keyframe", exp_v.is_keyframe, rsp_is_keyframe);
               check_field("on_frame", exp_v.on_frame, rsp_on_frame);
               check_field("changed", exp_v.changed, rsp_changed);
               check_field("unit_start_offset", exp_v.unit_start_offset,
                           rsp_unit_start_offset);
            end
         end
         if (req_valid && req_ready)
            awaited_verdicts.push_back(classify_byte(req_data_byte, req_byte_offset));
      end
      mismatch_count   <= fault_total;
      verdicts_awaited <= awaited_verdicts.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top: feeds Annex B byte beats to the keyframe detector and reports the verdict.
`timescale 1ns / 1ps

module tb_top;
   import hkad_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int          INTRO_BYTES  = 24;
   localparam int          STREAM_BYTES = 1450;
   localparam logic [INTRO_BYTES*8-1:0] INTRO = {
      8'hff,
      8'h00, 8'h00, 8'h01, 8'h09,
      8'h00, 8'h00, 8'h01, 8'h67,
      8'h00, 8'h00, 8'h01, 8'h65,
      8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h6a,
      8'h00, 8'h00, 8'h01, 8'h41
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic [OFFSET_BITS-1:0] req_byte_offset;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_start_found;
   logic [TYPE_BITS-1:0]   rsp_unit_type;
   logic                   rsp_is_keyframe;
   logic                   rsp_on_frame;
   logic                   rsp_changed;
   logic [OFFSET_BITS-1:0] rsp_unit_start_offset;
   int                     mismatch_count;
   int                     verdicts_awaited;

   logic [OFFSET_BITS-1:0] off_ctr;
   int                     bytes_sent = 0;
   logic                   no_gaps = 1'b0;
   int unsigned            cycle_count = 0;

   h264_keyframe_access_unit_detector_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_offset      (req_byte_offset),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_start_found      (rsp_start_found),
      .rsp_unit_type        (rsp_unit_type),
      .rsp_is_keyframe      (rsp_is_keyframe),
      .rsp_on_frame         (rsp_on_frame),
      .rsp_changed          (rsp_changed),
      .rsp_unit_start_offset(rsp_unit_start_offset)
   );

   hkad_au_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_byte_offset      (req_byte_offset),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_start_found      (rsp_start_found),
      .rsp_unit_type        (rsp_unit_type),
      .rsp_is_keyframe      (rsp_is_keyframe),
      .rsp_on_frame         (rsp_on_frame),
      .rsp_changed          (rsp_changed),
      .rsp_unit_start_offset(rsp_unit_start_offset),
      .mismatch_count       (mismatch_count),
      .verdicts_awaited     (verdicts_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   task automatic send_byte(input logic [7:0] d);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= d;
      req_byte_offset <= off_ctr;
      do @(posedge clock); while (!req_ready);
      off_ctr    = off_ctr + 1'b1;
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic await_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_awaited != 0);
   endtask

   initial begin
      int run;
      int stall;
      int r;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (r < 70)
            run = $urandom_range(1, 4);
         else if (r < 95)
            run = $urandom_range(5, 20);
         else
            run = $urandom_range(50, 200);
         r = $urandom_range(0, 99);
         if (r < 60)
            stall = $urandom_range(1, 2);
         else if (r < 95)
            stall = $urandom_range(3, 6);
         else
            stall = $urandom_range(10, 40);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
   end

   initial begin
      int                   i;
      int                   r;
      int                   len;
      int                   zeros;
      logic                 paused;
      logic [TYPE_BITS-1:0] kind;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= 8'h00;
      req_byte_offset <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The fifth byte, an AUD header, carries the all-ones offset; the count then wraps.
      off_ctr = {OFFSET_BITS{1'b1}} - 4;
      for (i = 0; i < INTRO_BYTES; i++)
         send_byte(INTRO[8*(INTRO_BYTES-1-i) +: 8]);
      await_drain();

      paused = 1'b0;
      while (bytes_sent < INTRO_BYTES + STREAM_BYTES) begin
         if ($urandom_range(0, 99) < 15) begin
            len = $urandom_range(1, 6);
            repeat (len) begin
               r = $urandom_range(0, 3);
               if (r == 0)
                  send_byte(8'h00);
               else if (r == 1)
                  send_byte(8'h01);
               else
                  send_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 12)
               kind = TYPE_AUD;
            else if (r < 22)
               kind = TYPE_SPS;
            else if (r < 30)
               kind = TYPE_PPS;
            else if (r < 36)
               kind = TYPE_SEI;
            else if (r < 60)
               kind = TYPE_BITS'($urandom_range(TYPE_SLICE, TYPE_IDR));
            else if (r < 66)
               kind = TYPE_EOSEQ;
            else if (r < 74)
               kind = TYPE_BITS'($urandom_range(TYPE_SPS_EXT + 1, TYPE_AUX_SLICE - 1));
            else
               kind = TYPE_BITS'($urandom_range(0, 31));
            if ($urandom_range(0, 9) == 0)
               off_ctr = OFFSET_BITS'({$urandom(), $urandom()});
            else if ($urandom_range(0, 29) == 0)
               off_ctr = {OFFSET_BITS{1'b1}} - OFFSET_BITS'($urandom_range(0, 8));
            zeros = ($urandom_range(0, 3) == 0) ? 3 : 2;
            if ($urandom_range(0, 19) == 0)
               zeros = 1;
            repeat (zeros) send_byte(8'h00);
            send_byte(8'h01);
            send_byte({3'($urandom_range(0, 7)), kind});
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
            repeat (len) send_byte(8'($urandom_range(1, 255)));
            if ($urandom_range(0, 19) == 0)
               no_gaps = ~no_gaps;
         end
         if (!paused && bytes_sent > INTRO_BYTES + STREAM_BYTES / 2) begin
            paused = 1'b1;
            await_drain();
         end
      end

      await_drain();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

/* h264_keyframe_access_unit_detector_top.f */
rtl/hkad_pkg.sv
rtl/hkad_front.sv
rtl/hkad_queue.sv
rtl/hkad_back.sv
rtl/h264_keyframe_access_unit_detector_top.sv
rtl/hkad_checker.sv
verif/hkad_au_checker.sv
verif/tb_top.sv
